// ===== src/gmdfs_pkg.sv =====
// Package for the grid maze depth-first search: sizes, codes, states and control structs.
`default_nettype none
package gmdfs_pkg;

  localparam int GRID_X = 16;
  localparam int GRID_Y = 16;
  localparam int CELLS  = GRID_X * GRID_Y;
  localparam int XW     = $clog2(GRID_X);
  localparam int YW     = $clog2(GRID_Y);
  localparam int SAW    = $clog2(CELLS);
  localparam int SPW    = $clog2(CELLS + 1);
  localparam int DIRW   = 3;
  localparam int CNTW   = 9;
  localparam int COORDW = 4;
  localparam int WALLW  = 16;

  localparam logic [CNTW-1:0] CNT_MAX     = '1;
  localparam logic [COORDW-1:0] GOAL_X_RST = 4'd8;
  localparam logic [COORDW-1:0] GOAL_Y_RST = 4'd11;

  localparam logic CFG_GOAL_X = 1'b0;
  localparam logic CFG_GOAL_Y = 1'b1;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [DIRW-1:0] DIR_YDEC = 3'd0;
  localparam logic [DIRW-1:0] DIR_XINC = 3'd1;
  localparam logic [DIRW-1:0] DIR_YINC = 3'd2;
  localparam logic [DIRW-1:0] DIR_XDEC = 3'd3;
  localparam logic [DIRW-1:0] DIR_DONE = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CHECK,
    ST_POP,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [1:0]    dir;
  } frame_t;

  typedef struct packed {
    logic load_wall;
    logic start_search;
    logic probe_issue;
    logic dir_inc;
    logic enter;
    logic pop_issue;
    logic pop_load;
    logic out_load;
    logic out_found;
  } cmd_t;

  typedef struct packed {
    logic start_is_goal;
    logic start_outside;
    logic top_done;
    logic stack_empty;
    logic nbr_outside;
    logic nbr_blocked;
    logic nbr_is_goal;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/gmdfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gmdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/gmdfs_ctrl.sv =====
// Search controller: sequences loads, probes, pushes, pops and result hand-off.
`default_nettype none
module gmdfs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_op,
  output logic               in_ready,
  input  wire gmdfs_pkg::sts_t sts,
  output gmdfs_pkg::cmd_t    cmd
);
  import gmdfs_pkg::*;

  state_t state_r, state_nxt;
  logic   found_r, found_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      found_r <= found_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    found_nxt     = found_r;
    cmd           = '0;
    cmd.out_found = found_r;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_LOAD) begin
            cmd.load_wall = 1'b1;
          end else begin
            cmd.start_search = 1'b1;
            if (sts.start_is_goal) begin
              found_nxt = 1'b1;
              state_nxt = ST_RESULT;
            end else if (sts.start_outside) begin
              found_nxt = 1'b0;
              state_nxt = ST_RESULT;
            end else begin
              state_nxt = ST_PROBE;
            end
          end
        end
      end
      ST_PROBE: begin
        if (sts.top_done) begin
          if (sts.stack_empty) begin
            found_nxt = 1'b0;
            state_nxt = ST_RESULT;
          end else begin
            cmd.pop_issue = 1'b1;
            state_nxt     = ST_POP;
          end
        end else if (sts.nbr_outside) begin
          cmd.dir_inc = 1'b1;
        end else begin
          cmd.probe_issue = 1'b1;
          state_nxt       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.dir_inc = 1'b1;
        state_nxt   = ST_PROBE;
        if (!sts.nbr_blocked) begin
          if (sts.nbr_is_goal) begin
            found_nxt = 1'b1;
            state_nxt = ST_RESULT;
          end else begin
            cmd.enter = 1'b1;
          end
        end
      end
      ST_POP: begin
        cmd.pop_load = 1'b1;
        state_nxt    = ST_PROBE;
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/gmdfs_dp.sv =====
// Search datapath: wall and visited rows, walk stack, top frame, count and result register.
`default_nettype none
module gmdfs_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire gmdfs_pkg::cmd_t               cmd,
  output gmdfs_pkg::sts_t                    sts,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [gmdfs_pkg::COORDW-1:0]  cfg_wdata,
  input  wire logic [gmdfs_pkg::COORDW-1:0]  line_index,
  input  wire logic [gmdfs_pkg::WALLW-1:0]   wall_bits,
  input  wire logic [gmdfs_pkg::COORDW-1:0]  start_x,
  input  wire logic [gmdfs_pkg::COORDW-1:0]  start_y,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic                               out_found,
  output logic [gmdfs_pkg::CNTW-1:0]         out_count
);
  import gmdfs_pkg::*;

  logic [COORDW-1:0] goal_x_r, goal_y_r;
  logic [XW-1:0]     top_x_r, nbr_x_r, nbr_x;
  logic [YW-1:0]     top_y_r, nbr_y_r, nbr_y;
  logic [DIRW-1:0]   top_dir_r;
  logic [SPW-1:0]    sp_r;
  logic [CNTW-1:0]   cnt_r;
  logic [GRID_X-1:0] wall_vld_r, vis_vld_r;
  logic              out_valid_r, out_found_r;
  logic [CNTW-1:0]   out_count_r;
  logic              nbr_outside;

  logic [GRID_Y-1:0] wall_rdata, vis_rdata, vis_wdata, wall_row, vis_row;
  logic [XW-1:0]     vis_waddr;
  logic              vis_we, wall_we;
  frame_t            push_frame, pop_frame;
  logic [SPW-1:0]    sp_dec;

  always_comb begin
    nbr_x       = top_x_r;
    nbr_y       = top_y_r;
    nbr_outside = 1'b0;
    case (top_dir_r)
      DIR_YDEC: begin
        nbr_y       = top_y_r - YW'(1);
        nbr_outside = (top_y_r == '0);
      end
      DIR_XINC: begin
        nbr_x       = top_x_r + XW'(1);
        nbr_outside = (top_x_r == XW'(GRID_X - 1));
      end
      DIR_YINC: begin
        nbr_y       = top_y_r + YW'(1);
        nbr_outside = (top_y_r == YW'(GRID_Y - 1));
      end
      DIR_XDEC: begin
        nbr_x       = top_x_r - XW'(1);
        nbr_outside = (top_x_r == '0);
      end
      default: begin
        nbr_outside = 1'b1;
      end
    endcase
  end

  assign wall_row = wall_vld_r[nbr_x_r] ? wall_rdata : '0;
  assign vis_row  = vis_vld_r[nbr_x_r] ? vis_rdata : '0;

  assign sts.start_is_goal = (start_x == goal_x_r) && (start_y == goal_y_r);
  assign sts.start_outside = (32'(start_x) >= GRID_X) || (32'(start_y) >= GRID_Y);
  assign sts.top_done      = (top_dir_r >= DIR_DONE);
  assign sts.stack_empty   = (sp_r == '0);
  assign sts.nbr_outside   = nbr_outside;
  assign sts.nbr_blocked   = wall_row[nbr_y_r] || vis_row[nbr_y_r];
  assign sts.nbr_is_goal   = (32'(nbr_x_r) == 32'(goal_x_r)) && (32'(nbr_y_r) == 32'(goal_y_r));
  assign sts.out_free      = !out_valid_r || out_ready;

  // wall rows
  assign wall_we = cmd.load_wall && (32'(line_index) < GRID_X);

  gmdfs_ram #(.WIDTH(GRID_Y), .DEPTH(GRID_X)) u_wall (
    .clk   (clk),
    .we    (wall_we),
    .waddr (XW'(line_index)),
    .wdata (GRID_Y'(wall_bits)),
    .re    (cmd.probe_issue),
    .raddr (nbr_x),
    .rdata (wall_rdata)
  );

  // visited rows: read-modify-write on enter, fresh row on search start
  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = nbr_x_r;
    vis_wdata = vis_row | (GRID_Y'(1) << nbr_y_r);
    if (cmd.start_search) begin
      vis_we    = !sts.start_outside;
      vis_waddr = XW'(start_x);
      vis_wdata = GRID_Y'(1) << YW'(start_y);
    end else if (cmd.enter) begin
      vis_we = 1'b1;
    end
  end

  gmdfs_ram #(.WIDTH(GRID_Y), .DEPTH(GRID_X)) u_vis (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .re    (cmd.probe_issue),
    .raddr (nbr_x),
    .rdata (vis_rdata)
  );

  // walk stack holds the frames below the top; dir is the last direction probed
  assign push_frame = '{x: top_x_r, y: top_y_r, dir: top_dir_r[1:0]};
  assign sp_dec     = sp_r - SPW'(1);

  gmdfs_ram #(.WIDTH($bits(frame_t)), .DEPTH(CELLS)) u_stack (
    .clk   (clk),
    .we    (cmd.enter),
    .waddr (sp_r[SAW-1:0]),
    .wdata (push_frame),
    .re    (cmd.pop_issue),
    .raddr (sp_dec[SAW-1:0]),
    .rdata (pop_frame)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r    <= GOAL_X_RST;
      goal_y_r    <= GOAL_Y_RST;
      wall_vld_r  <= '0;
      vis_vld_r   <= '0;
      top_dir_r   <= DIR_DONE;
      sp_r        <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GOAL_X: goal_x_r <= cfg_wdata;
          CFG_GOAL_Y: goal_y_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (wall_we) begin
        wall_vld_r[XW'(line_index)] <= 1'b1;
      end
      if (cmd.start_search) begin
        sp_r      <= '0;
        top_dir_r <= DIR_YDEC;
        if (!sts.start_outside && !sts.start_is_goal) begin
          vis_vld_r <= GRID_X'(1) << start_x;
          cnt_r     <= CNTW'(1);
        end else begin
          vis_vld_r <= '0;
          cnt_r     <= '0;
        end
      end else if (cmd.enter) begin
        vis_vld_r[nbr_x_r] <= 1'b1;
        sp_r               <= sp_r + SPW'(1);
        top_dir_r          <= DIR_YDEC;
        if (cnt_r != CNT_MAX) begin
          cnt_r <= cnt_r + CNTW'(1);
        end
      end else if (cmd.pop_load) begin
        sp_r      <= sp_dec;
        top_dir_r <= DIRW'(pop_frame.dir) + DIRW'(1);
      end else if (cmd.dir_inc) begin
        top_dir_r <= top_dir_r + DIRW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_search) begin
      top_x_r <= XW'(start_x);
      top_y_r <= YW'(start_y);
    end else if (cmd.enter) begin
      top_x_r <= nbr_x_r;
      top_y_r <= nbr_y_r;
    end else if (cmd.pop_load) begin
      top_x_r <= pop_frame.x;
      top_y_r <= pop_frame.y;
    end
    if (cmd.probe_issue) begin
      nbr_x_r <= nbr_x;
      nbr_y_r <= nbr_y;
    end
    if (cmd.out_load) begin
      out_found_r <= cmd.out_found;
      out_count_r <= cmd.out_found && sts.start_is_goal && (cnt_r == '0) ? '0 : cnt_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_count = out_count_r;

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enter |-> (32'(sp_r) < CELLS - 1))
    else $error("walk stack overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_issue |-> (sp_r != '0))
    else $error("pop from empty walk stack");
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwritten while stalled");
  a_probe_dir: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe_issue |-> (top_dir_r < DIR_DONE) && !nbr_outside)
    else $error("probe issued without a valid neighbor");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enter |=> (cnt_r != '0) && (sp_r != '0))
    else $error("enter did not update count and stack");

endmodule
`default_nettype wire

// ===== src/grid_maze_depth_first_search.sv =====
// Grid maze depth-first search, top level: stream ports, controller and datapath.
//
// Input items on in_*: op = 0 loads one wall line (row line_index, bit k is
// cell (line_index, k)); op = 1 runs a depth-first search from (start_x, start_y)
// toward the goal held in registers goal_x (index 0) and goal_y (index 1).
// Neighbors are probed in the order y-1, x+1, y+1, x-1.
// A load item gives no result; a search item gives one item on out_* with
// found and cells_visited.
// A load is written in the idle state. A search probes each neighbor in turn: a
// probe that leaves the grid only steps the direction, one inside it reads the
// wall and visited rows and then checks them, and a backtrack reads the walk stack.
// The walk is bound by one read of the wall and visited rows per probe and
// one walk stack access per push or backtrack. One item is in work at a time.
// Reset: walls clear, goal returns to (8, 11), no result pending.
// A finished result sits in an output register; while the receiver stalls the
// block still takes new items, and only the next search result waits for it.
`default_nettype none
module grid_maze_depth_first_search (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // op, line_index[3:0], wall_bits[15:0], start_x[3:0], start_y[3:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // found, cells_visited[8:0]
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [3:0]  cfg_wdata
);
  import gmdfs_pkg::*;

  cmd_t            cmd;
  sts_t            sts;
  logic            out_found;
  logic [CNTW-1:0] out_count;

  gmdfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tdata[0]),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gmdfs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .line_index (in_tdata[4:1]),
    .wall_bits  (in_tdata[20:5]),
    .start_x    (in_tdata[24:21]),
    .start_y    (in_tdata[28:25]),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_found  (out_found),
    .out_count  (out_count)
  );

  assign out_tdata = {6'd0, out_count, out_found};

endmodule
`default_nettype wire

// ===== test/maze_search_checker.sv =====
// Checker for the maze search: predicts each search result and compares it with out_tdata.
`timescale 1ns / 1ps
module maze_search_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,   // op, line_index[3:0], wall_bits[15:0], start_x[3:0], start_y[3:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // found, cells_visited[8:0]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_wdata,
  output int          fail_count = 0,
  output int          pending = 0
);
  import gmdfs_pkg::*;

  typedef struct packed {
    logic            found;
    logic [CNTW-1:0] visited;
  } walk_result_t;

  logic [COORDW-1:0] goal_x = GOAL_X_RST;
  logic [COORDW-1:0] goal_y = GOAL_Y_RST;
  logic [GRID_Y-1:0] wall_rows [GRID_X];
  walk_result_t      expected_walks [$];

  function automatic walk_result_t walk_maze(input int sx, input int sy);
    logic [GRID_Y-1:0] seen [GRID_X];
    int                stk_x [CELLS];
    int                stk_y [CELLS];
    logic [DIRW-1:0]   stk_dir [CELLS];
    int                depth;
    int                top;
    int                nx;
    int                ny;
    walk_result_t      res;
    res = '0;
    for (int i = 0; i < GRID_X; i++) seen[i] = '0;
    if (sx == goal_x && sy == goal_y) begin
      res.found = 1'b1;
      return res;
    end
    // start cell is entered without a wall test
    seen[sx][sy] = 1'b1;
    res.visited = CNTW'(1);
    stk_x[0] = sx;
    stk_y[0] = sy;
    stk_dir[0] = DIR_YDEC;
    depth = 1;
    while (depth > 0 && !res.found) begin
      top = depth - 1;
      if (stk_dir[top] == DIR_DONE) begin
        depth--;
      end else begin
        nx = stk_x[top];
        ny = stk_y[top];
        case (stk_dir[top])
          DIR_YDEC: ny--;
          DIR_XINC: nx++;
          DIR_YINC: ny++;
          default:  nx--;
        endcase
        stk_dir[top] = stk_dir[top] + 1'b1;
        if (nx >= 0 && nx < GRID_X && ny >= 0 && ny < GRID_Y &&
            !wall_rows[nx][ny] && !seen[nx][ny]) begin
          if (nx == goal_x && ny == goal_y) begin
            res.found = 1'b1;
          end else begin
            seen[nx][ny] = 1'b1;
            if (res.visited != CNT_MAX) res.visited++;
            stk_x[depth] = nx;
            stk_y[depth] = ny;
            stk_dir[depth] = DIR_YDEC;
            depth++;
          end
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    walk_result_t    want;
    logic            got_found;
    logic [CNTW-1:0] got_visited;
    if (!rst_n) begin
      goal_x = GOAL_X_RST;
      goal_y = GOAL_Y_RST;
      for (int i = 0; i < GRID_X; i++) wall_rows[i] = '0;
      expected_walks.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got_found = out_tdata[0];
        got_visited = out_tdata[9:1];
        if (expected_walks.size() == 0) begin
          $display("%0t: unexpected result item, expected none, got found %0d visited %0d",
                   $time, got_found, got_visited);
          fail_count++;
        end else begin
          want = expected_walks.pop_front();
          if (got_found !== want.found) begin
            $display("%0t: found mismatch, expected %0d got %0d",
                     $time, want.found, got_found);
            fail_count++;
          end
          if (got_visited !== want.visited) begin
            $display("%0t: cells_visited mismatch, expected %0d got %0d",
                     $time, want.visited, got_visited);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tdata[0] == OP_SEARCH)
          expected_walks.push_back(walk_maze(int'(in_tdata[24:21]), int'(in_tdata[28:25])));
        else
          wall_rows[in_tdata[4:1]] = in_tdata[20:5];
      end
      if (cfg_we) begin
        if (cfg_index == CFG_GOAL_X) goal_x = cfg_wdata;
        else goal_y = cfg_wdata;
      end
    end
    pending = expected_walks.size();
  end

endmodule

// ===== test/grid_maze_depth_first_search_test.sv =====
// Testbench top for the grid maze depth-first search: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module grid_maze_depth_first_search_test;
  import gmdfs_pkg::*;

  localparam int CYCLE_LIMIT      = 8000000;
  localparam int DRAIN_CYCLES     = 8;
  localparam int SINK_HOLD_CYCLES = 6000;
  localparam int PHASES           = 21;
  localparam int PHASE_ITEMS      = 27;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [31:0] in_tdata = '0;
  logic        out_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_GOAL_X;
  logic [3:0]  cfg_wdata = '0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [15:0] out_tdata;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  logic        src_calm = 1'b0;
  logic        sink_hold = 1'b0;
  logic [3:0]  goal_now_x = GOAL_X_RST;
  logic [3:0]  goal_now_y = GOAL_Y_RST;

  grid_maze_depth_first_search u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  maze_search_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : result_sink
    int   gap;
    int   n;
    logic calm;
    n = 0;
    calm = 1'b0;
    forever begin
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      n++;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (sink_hold) begin
        gap = SINK_HOLD_CYCLES;
        sink_hold = 1'b0;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic send_item(input logic op, input logic [3:0] line, input logic [15:0] bits,
                           input logic [3:0] sx, input logic [3:0] sy);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= {3'b000, sy, sx, bits, line, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic load_line(input logic [3:0] line, input logic [15:0] bits);
    send_item(OP_LOAD, line, bits, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
  endtask

  task automatic search(input logic [3:0] sx, input logic [3:0] sy);
    send_item(OP_SEARCH, 4'($urandom_range(0, 15)), 16'($urandom), sx, sy);
  endtask

  // wait for every result, then let a trailing load settle
  task automatic drain;
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_goal(input logic [3:0] gx, input logic [3:0] gy);
    cfg_we <= 1'b1;
    cfg_index <= CFG_GOAL_X;
    cfg_wdata <= gx;
    @(posedge clk);
    cfg_index <= CFG_GOAL_Y;
    cfg_wdata <= gy;
    @(posedge clk);
    cfg_we <= 1'b0;
    goal_now_x = gx;
    goal_now_y = gy;
  endtask

  initial begin : stimulus
    int          density;
    logic [15:0] bits;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // start on the reset goal, then an open grid
    search(4'd8, 4'd11);
    search(4'd0, 4'd0);
    // goal walled off
    load_line(4'd8, 16'h0800);
    search(4'd0, 4'd0);
    load_line(4'd8, 16'h0000);
    // start on a wall
    load_line(4'd3, 16'h0008);
    search(4'd3, 4'd3);
    // start boxed in a corner
    load_line(4'd1, 16'h0001);
    load_line(4'd0, 16'h0002);
    search(4'd0, 4'd0);
    load_line(4'd15, 16'hFFFF);
    search(4'd15, 4'd15);
    search(4'd15, 4'd0);
    search(4'd0, 4'd15);
    drain;
    set_goal(4'd0, 4'd0);
    search(4'd15, 4'd15);
    search(4'd0, 4'd0);
    drain;
    set_goal(4'd15, 4'd15);
    search(4'd0, 4'd15);
    load_line(4'd15, 16'h0000);
    load_line(4'd0, 16'h0000);
    load_line(4'd1, 16'h0000);
    search(4'd0, 4'd0);
    drain;
    set_goal(4'd15, 4'd0);
    search(4'd0, 4'd15);
    drain;
    set_goal(4'd0, 4'd15);
    search(4'd15, 4'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain;
      case (ph % 4)
        0: set_goal(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        1: set_goal(4'd15, 4'd15);
        2: set_goal(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        default: set_goal(4'd0, 4'd0);
      endcase
      src_calm = ($urandom_range(0, 3) == 0);
      density = $urandom_range(0, 4);
      if (ph == PHASES / 2) sink_hold = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 9) < 4) begin
          case (density)
            0: bits = 16'($urandom & $urandom & $urandom);
            1: bits = 16'($urandom & $urandom);
            2: bits = 16'($urandom);
            3: bits = 16'($urandom | $urandom);
            default: bits = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          endcase
          load_line(4'($urandom_range(0, 15)), bits);
        end else if ($urandom_range(0, 15) == 0) begin
          search(goal_now_x, goal_now_y);
        end else begin
          search(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
        end
      end
    end
    drain;

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/gmdfs_pkg.sv
src/gmdfs_ram.sv
src/gmdfs_ctrl.sv
src/gmdfs_dp.sv
src/grid_maze_depth_first_search.sv
test/maze_search_checker.sv
test/grid_maze_depth_first_search_test.sv
